/* sv/ucb_pkg.sv */
`default_nettype none
package ucb_pkg;

	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int ROW_W    = 4;
	localparam int COL_W    = 4;
	localparam int CELLS    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = ROW_W + COL_W;

	localparam logic [31:0] LN2_Q16  = 32'd45426;
	localparam logic [23:0] MEAN_MIN = 24'h800000;

	typedef enum logic [1:0] {
		CFG_GAIN      = 2'd0,
		CFG_MAX_STEPS = 2'd1,
		CFG_ROWS      = 2'd2,
		CFG_COLS      = 2'd3
	} cfg_idx_t;

	localparam logic FUNC_CHOOSE = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	typedef struct packed {
		logic               func;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [15:0] signal;
	} ucb_in_t;

	typedef struct packed {
		logic [3:0]         chosen_row;
		logic [3:0]         chosen_col;
		logic               done_res;
		logic signed [23:0] best_mean;
		logic [15:0]        stable_count;
		logic [15:0]        step_count;
	} ucb_out_t;

endpackage
`default_nettype wire

/* sv/ucb_grid_cell_selector.sv */
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | in_data  (func, row, col, signal)
// out     | output    | out_valid/out_stall | out_data (chosen cell and status)
// cfg     | input     | cfg_we            | cfg_index, cfg_data
// a report item goes through two reads, a 36-step restoring divide,
// write-back and result
// a choose item scans up to 256 cells for an unvisited cell, else works out ln
// and then, per cell in use, a 36-step divide and an 18-step root
// one shared divider, root unit and multiplier; the block takes one item at a time
// reset clears the visited bits at once, so no clearing pass is needed
// a new item is taken while the last result still waits on a stalled output
`default_nettype none
module ucb_grid_cell_selector (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ucb_pkg::ucb_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ucb_pkg::ucb_out_t      out_data,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);
	import ucb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_FREE, S_LN_INIT, S_LN_SQ, S_LN_MUL, S_CELL_RD, S_CELL_LD,
		S_DIV, S_SQRT, S_MUL, S_CMP, S_REP_RD, S_REP_LD, S_REP_WR, S_FIN
	} state_t;

	localparam logic [4:0] MAX_R5 = 5'(MAX_ROWS);
	localparam logic [4:0] MAX_C5 = 5'(MAX_COLS);

	state_t state_q;

	// configuration
	logic [15:0] gain_q, max_steps_q;
	logic [4:0]  rows_cfg_q, cols_cfg_q;
	logic [3:0]  rows_m1, cols_m1;

	// item
	logic               func_q;
	logic signed [15:0] sig_q;
	logic [ADDR_W-1:0]  addr_q, win_q;

	// cell store, a visited bit per cell stands in for the zero reset
	logic [23:0]       mean_mem [CELLS];
	logic [15:0]       visit_mem [CELLS];
	logic [CELLS-1:0]  valid_q;
	logic [23:0]       rd_mean_q;
	logic [15:0]       rd_visit_q;
	logic              rd_valid_q;
	logic signed [23:0] mean_eff;
	logic [15:0]       visit_eff;

	// global status
	logic [15:0]        step_q, stable_q;
	logic signed [23:0] best_ever_q, last_best_q;

	// shared arithmetic
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [5:0]  cnt_q;
	logic [4:0]  e_q;
	logic [30:0] m_q;
	logic [15:0] frac_q;
	logic [19:0] ln_q;
	logic [35:0] quo_q;
	logic [16:0] rem_q, div_q;
	logic [18:0] srem_q;
	logic [17:0] root_q;
	logic [21:0] ex_q;
	logic signed [25:0] best_q;
	logic        best_valid_q;
	logic [15:0] vn_q;
	logic        neg_q;

	// result register
	logic     out_valid_q;
	ucb_out_t out_q;
	logic     out_load;

	// combinational helpers
	logic [16:0] n_ln;
	logic [4:0]  e_ln;
	logic [30:0] m_init;
	logic [31:0] sq_t;
	logic [17:0] div_sh;
	logic        div_ge;
	logic [20:0] sq_r2, sq_trial;
	logic        sq_ge;
	logic signed [25:0] score, delta, mean_w, qt;
	logic [25:0] delta_mag;
	logic signed [23:0] mean_new, best_next;
	logic        last_cell;
	logic [ADDR_W-1:0] addr_next;
	logic [17:0] st3, mx2;
	logic        done;
	logic [15:0] vn_next;
	logic        in_grid;

	always_comb begin
		if (rows_cfg_q == 5'd0) rows_m1 = 4'd0;
		else if (rows_cfg_q > MAX_R5) rows_m1 = 4'(MAX_R5 - 5'd1);
		else rows_m1 = 4'(rows_cfg_q - 5'd1);
		if (cols_cfg_q == 5'd0) cols_m1 = 4'd0;
		else if (cols_cfg_q > MAX_C5) cols_m1 = 4'(MAX_C5 - 5'd1);
		else cols_m1 = 4'(cols_cfg_q - 5'd1);
	end

	assign in_grid   = (in_data.row <= rows_m1) && (in_data.col <= cols_m1);
	assign last_cell = (addr_q[ADDR_W-1:COL_W] == rows_m1) && (addr_q[COL_W-1:0] == cols_m1);
	always_comb begin
		if (addr_q[COL_W-1:0] == cols_m1)
			addr_next = {addr_q[ADDR_W-1:COL_W] + 4'd1, 4'd0};
		else
			addr_next = {addr_q[ADDR_W-1:COL_W], addr_q[COL_W-1:0] + 4'd1};
	end

	assign mean_eff  = rd_valid_q ? $signed(rd_mean_q) : 24'sd0;
	assign visit_eff = rd_valid_q ? rd_visit_q : 16'd0;

	// shared multiplier
	always_comb begin
		unique case (state_q)
			S_LN_SQ: begin
				mul_a = {1'b0, m_q};
				mul_b = {1'b0, m_q};
			end
			S_LN_MUL: begin
				mul_a = {11'd0, e_q, frac_q};
				mul_b = LN2_Q16;
			end
			S_MUL: begin
				mul_a = {14'd0, root_q};
				mul_b = {16'd0, gain_q};
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	// log2 set-up: exponent and normalised mantissa of steps plus one
	always_comb begin
		n_ln = {1'b0, step_q} + 17'd1;
		e_ln = 5'd0;
		for (int i = 0; i < 17; i++)
			if (n_ln[i]) e_ln = 5'(i);
		m_init = 31'({14'd0, n_ln} << (5'd30 - e_ln));
	end
	assign sq_t = mul_p[61:30];

	// divider and root steps
	assign div_sh   = {rem_q, quo_q[35]};
	assign div_ge   = div_sh >= {1'b0, div_q};
	assign sq_r2    = {srem_q, quo_q[35:34]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = sq_r2 >= sq_trial;

	assign score = {{2{mean_eff[23]}}, mean_eff} + $signed({4'd0, ex_q});

	// running mean update
	assign vn_next   = (visit_eff == 16'hFFFF) ? visit_eff : visit_eff + 16'd1;
	assign delta     = $signed({{2{sig_q[15]}}, sig_q, 8'd0}) - {{2{mean_eff[23]}}, mean_eff};
	assign delta_mag = delta[25] ? 26'(-delta) : 26'(delta);
	assign qt        = neg_q ? -$signed({1'b0, quo_q[24:0]}) : $signed({1'b0, quo_q[24:0]});
	assign mean_w    = {{2{mean_eff[23]}}, mean_eff} + qt;
	assign mean_new  = mean_w[23:0];
	assign best_next = (mean_new > best_ever_q) ? mean_new : best_ever_q;

	// done when the step limit is met or the stable run passes two thirds of it
	assign st3  = {2'd0, stable_q} + {1'b0, stable_q, 1'b0};
	assign mx2  = {1'b0, max_steps_q, 1'b0};
	assign done = (step_q >= max_steps_q) || (st3 > mx2);

	// result register loads once the previous result has gone or is leaving
	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= 16'd4096;
			max_steps_q <= 16'd1000;
			rows_cfg_q  <= 5'd16;
			cols_cfg_q  <= 5'd16;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GAIN:      gain_q      <= cfg_data;
				CFG_MAX_STEPS: max_steps_q <= cfg_data;
				CFG_ROWS:      rows_cfg_q  <= cfg_data[4:0];
				CFG_COLS:      cols_cfg_q  <= cfg_data[4:0];
			endcase
		end
	end

	// cell store, read data registered
	always_ff @(posedge clk) begin
		if (state_q == S_REP_WR) begin
			mean_mem[addr_q]  <= mean_new;
			visit_mem[addr_q] <= vn_q;
		end
		rd_mean_q  <= mean_mem[addr_q];
		rd_visit_q <= visit_mem[addr_q];
		rd_valid_q <= valid_q[addr_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			step_q       <= 16'd0;
			stable_q     <= 16'd0;
			best_ever_q  <= $signed(MEAN_MIN);
			last_best_q  <= $signed(MEAN_MIN);
			out_valid_q  <= 1'b0;
			best_valid_q <= 1'b0;
			cnt_q        <= 6'd0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q <= in_data.func;
						sig_q  <= in_data.signal;
						win_q  <= '0;
						if (in_data.func == FUNC_REPORT) begin
							addr_q  <= {in_data.row, in_data.col};
							state_q <= in_grid ? S_REP_RD : S_FIN;
						end else begin
							addr_q  <= '0;
							state_q <= S_FREE;
						end
					end
				end
				S_FREE: begin
					if (!valid_q[addr_q]) begin
						win_q   <= addr_q;
						state_q <= S_FIN;
					end else if (last_cell) begin
						addr_q  <= '0;
						state_q <= S_LN_INIT;
					end else begin
						addr_q <= addr_next;
					end
				end
				S_LN_INIT: begin
					e_q     <= e_ln;
					m_q     <= m_init;
					frac_q  <= 16'd0;
					cnt_q   <= 6'd15;
					state_q <= S_LN_SQ;
				end
				S_LN_SQ: begin
					m_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
					frac_q <= {frac_q[14:0], sq_t[31]};
					cnt_q  <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) state_q <= S_LN_MUL;
				end
				S_LN_MUL: begin
					ln_q         <= mul_p[35:16];
					best_valid_q <= 1'b0;
					state_q      <= S_CELL_RD;
				end
				S_CELL_RD: state_q <= S_CELL_LD;
				S_CELL_LD: begin
					quo_q   <= {ln_q, 16'd0};
					div_q   <= {1'b0, visit_eff} + 17'd1;
					rem_q   <= 17'd0;
					cnt_q   <= 6'd35;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= div_ge ? 17'(div_sh - {1'b0, div_q}) : div_sh[16:0];
					quo_q <= {quo_q[34:0], div_ge};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						if (func_q == FUNC_CHOOSE) begin
							srem_q  <= 19'd0;
							root_q  <= 18'd0;
							cnt_q   <= 6'd17;
							state_q <= S_SQRT;
						end else begin
							state_q <= S_REP_WR;
						end
					end
				end
				S_SQRT: begin
					srem_q <= sq_ge ? 19'(sq_r2 - sq_trial) : sq_r2[18:0];
					root_q <= {root_q[16:0], sq_ge};
					quo_q  <= {quo_q[33:0], 2'b00};
					cnt_q  <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) state_q <= S_MUL;
				end
				S_MUL: begin
					ex_q    <= mul_p[33:12];
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!best_valid_q || score > best_q) begin
						best_q       <= score;
						best_valid_q <= 1'b1;
						win_q        <= addr_q;
					end
					if (last_cell) begin
						state_q <= S_FIN;
					end else begin
						addr_q  <= addr_next;
						state_q <= S_CELL_RD;
					end
				end
				S_REP_RD: state_q <= S_REP_LD;
				S_REP_LD: begin
					vn_q    <= vn_next;
					neg_q   <= delta[25];
					quo_q   <= {10'd0, delta_mag};
					div_q   <= {1'b0, vn_next};
					rem_q   <= 17'd0;
					cnt_q   <= 6'd35;
					state_q <= S_DIV;
				end
				S_REP_WR: begin
					valid_q[addr_q] <= 1'b1;
					best_ever_q     <= best_next;
					if (step_q != 16'hFFFF) step_q <= step_q + 16'd1;
					if (best_next > last_best_q) begin
						stable_q    <= 16'd0;
						last_best_q <= best_next;
					end else if (stable_q != 16'hFFFF) begin
						stable_q <= stable_q + 16'd1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						out_q.chosen_row         <= (func_q == FUNC_REPORT) ? 4'd0 : win_q[ADDR_W-1:COL_W];
						out_q.chosen_col         <= (func_q == FUNC_REPORT) ? 4'd0 : win_q[COL_W-1:0];
						out_q.done_res           <= done;
						out_q.best_mean          <= best_ever_q;
						out_q.stable_count       <= stable_q;
						out_q.step_count         <= step_q;
						state_q                  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_best_not_below_last: assert property (@(posedge clk) disable iff (!arst_n)
		best_ever_q >= last_best_q) else $error("best mean fell below last best");
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < div_q) else $error("divider remainder out of range");
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN)) else $error("result loaded outside fin");
	a_write_marks_visited: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REP_WR |=> valid_q[$past(addr_q)]) else $error("reported cell not marked");
`endif

endmodule
`default_nettype wire

/* tb/ucb_grid_cell_selector_test.sv */
`timescale 1ns / 100ps
module ucb_grid_cell_selector_test;
	import ucb_pkg::*;

	// clock, reset and the block's ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ucb_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ucb_out_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	ucb_grid_cell_selector i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the block: registers and per-cell statistics
	logic [15:0] gain_q = 16'd4096;
	logic [15:0] step_limit = 16'd1000;
	logic [4:0] rows_q = 5'd16;
	logic [4:0] cols_q = 5'd16;
	logic [15:0] visits [CELLS];
	logic signed [23:0] means [CELLS];
	logic [15:0] reports_total = '0;
	logic signed [23:0] best_ever = MEAN_MIN;
	logic signed [23:0] best_seen = MEAN_MIN;
	logic [15:0] flat_run = '0;

	ucb_out_t pending_results [$];
	ucb_out_t got;
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int chooses_sent = 0;
	int stall_left = 0;
	bit hold_req = 1'b0;
	bit quiet = 1'b0;

	// directed stimulus table
	typedef struct {
		bit is_cfg;
		cfg_idx_t idx;
		logic [15:0] val;
		ucb_in_t item;
		bit typed;
		ucb_out_t res;
	} step_t;
	step_t steps [$];

	initial begin
		foreach (visits[i]) begin
			visits[i] = '0;
			means[i] = '0;
		end
	end

	// natural log in Q.16: log2 by repeated squaring, then times ln 2
	function automatic logic [63:0] ln_q16(input logic [63:0] n);
		int e;
		logic [63:0] m;
		logic [63:0] frac;
		e = 0;
		frac = '0;
		while (e < 40 && (n >> (e + 1)) != 0)
			e++;
		m = (e <= 30) ? (n << (30 - e)) : (n >> (e - 30));
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac[i] = 1'b1;
			end
		end
		return (((64'(e) << 16) | frac) * 64'd45426) >> 16;
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = '0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic int dim(input logic [4:0] v, input int hi);
		if (v < 1)
			return 1;
		return (v > hi) ? hi : int'(v);
	endfunction

	// works out the status result of one item and moves the shadow state on
	task automatic select_cell(input ucb_in_t x, output ucb_out_t y);
		int nr;
		int nc;
		int k;
		bit found;
		logic [63:0] lnv;
		logic [63:0] q;
		logic [63:0] ex;
		longint top;
		longint score;
		longint s;
		longint delta;
		nr = dim(rows_q, MAX_ROWS);
		nc = dim(cols_q, MAX_COLS);
		y = '0;
		found = 1'b0;
		if (x.func == FUNC_CHOOSE) begin
			for (int r = 0; r < nr && !found; r++)
				for (int c = 0; c < nc && !found; c++)
					if (visits[r * MAX_COLS + c] == 0) begin
						y.chosen_row = 4'(r);
						y.chosen_col = 4'(c);
						found = 1'b1;
					end
			if (!found) begin
				lnv = ln_q16(64'(reports_total) + 64'd1);
				top = 64'sh8000_0000_0000_0000;
				for (int r = 0; r < nr; r++)
					for (int c = 0; c < nc; c++) begin
						k = r * MAX_COLS + c;
						q = (lnv << 16) / (64'(visits[k]) + 64'd1);
						ex = (64'(gain_q) * root64(q)) >> 12;
						score = longint'(means[k]) + longint'(ex);
						// strict compare keeps the earliest cell on a tie
						if (score > top) begin
							top = score;
							y.chosen_row = 4'(r);
							y.chosen_col = 4'(c);
						end
					end
			end
		end else if (x.row < nr && x.col < nc) begin
			k = x.row * MAX_COLS + x.col;
			s = longint'(x.signal) * 256;
			if (visits[k] != 16'hFFFF)
				visits[k] = visits[k] + 16'd1;
			delta = s - longint'(means[k]);
			means[k] = 24'(longint'(means[k]) + delta / longint'(visits[k]));
			if (means[k] > best_ever)
				best_ever = means[k];
			if (reports_total != 16'hFFFF)
				reports_total = reports_total + 16'd1;
			if (best_ever > best_seen) begin
				flat_run = '0;
				best_seen = best_ever;
			end else if (flat_run != 16'hFFFF) begin
				flat_run = flat_run + 16'd1;
			end
		end
		y.done_res = (reports_total >= step_limit)
			|| (longint'(flat_run) * 3 > longint'(step_limit) * 2);
		y.best_mean = best_ever;
		y.stable_count = flat_run;
		y.step_count = reports_total;
	endtask

	// offer one item after a random gap; the expectation is queued on acceptance
	task automatic send_item(input ucb_in_t x, input bit typed, input ucb_out_t res);
		int gap;
		ucb_out_t y;
		gap = quiet ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		do
			@(posedge clk);
		while (in_stall);
		select_cell(x, y);
		pending_results.push_back(typed ? res : y);
		items_sent++;
		if (x.func == FUNC_CHOOSE)
			chooses_sent++;
	endtask

	// drop valid and wait until every expected result has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register writes only once the block has gone quiet
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_GAIN: gain_q = v;
			CFG_MAX_STEPS: step_limit = v;
			CFG_ROWS: rows_q = v[4:0];
			default: cols_q = v[4:0];
		endcase
	endtask

	task automatic add_cfg(input cfg_idx_t idx, input logic [15:0] v);
		step_t t;
		t.is_cfg = 1'b1;
		t.idx = idx;
		t.val = v;
		t.item = '0;
		t.typed = 1'b0;
		t.res = '0;
		steps.push_back(t);
	endtask

	task automatic add_item(input logic f, input logic [3:0] r, input logic [3:0] c,
		input logic [15:0] sig, input bit typed, input ucb_out_t res);
		step_t t;
		t.is_cfg = 1'b0;
		t.idx = CFG_GAIN;
		t.val = '0;
		t.item = '{func: f, row: r, col: c, signal: sig};
		t.typed = typed;
		t.res = res;
		steps.push_back(t);
	endtask

	function automatic ucb_out_t status(input logic [3:0] r, input logic [3:0] c,
		input logic d, input logic [23:0] b, input logic [15:0] st, input logic [15:0] n);
		return '{chosen_row: r, chosen_col: c, done_res: d, best_mean: b,
			stable_count: st, step_count: n};
	endfunction

	task automatic field_check(input string f, input longint e, input longint a);
		if (e != a) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, f, e, a);
		end
	endtask

	// receiver: random stall before each result, plus one long hold on request
	always @(negedge clk) begin
		if (hold_req) begin
			stall_left = 400;
			hold_req = 1'b0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker: each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			stall_left = quiet ? 0 : $urandom_range(0, 17);
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, got %p", $time, out_data);
			end else begin
				got = pending_results.pop_front();
				field_check("chosen_row", got.chosen_row, out_data.chosen_row);
				field_check("chosen_col", got.chosen_col, out_data.chosen_col);
				field_check("done_res", got.done_res, out_data.done_res);
				field_check("best_mean", got.best_mean, out_data.best_mean);
				field_check("stable_count", got.stable_count, out_data.stable_count);
				field_check("step_count", got.step_count, out_data.step_count);
			end
		end
	end

	// watchdog: several times a run of nothing but full-grid scans with maximum stalls
	initial begin
		#200_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int nr;
		int nc;
		int pick;
		ucb_in_t x;
		logic [15:0] v;

		// directed part: reset state, extremes of the signal, grid clamping,
		// report outside the grid, zero step limit, zero and full gain
		add_item(FUNC_CHOOSE, 0, 0, 16'h0000, 1'b1, status(0, 0, 0, MEAN_MIN, 0, 0));
		add_item(FUNC_REPORT, 0, 0, 16'h7FFF, 1'b1, status(0, 0, 0, 24'h7FFF00, 0, 1));
		add_item(FUNC_REPORT, 15, 15, 16'h8000, 1'b1, status(0, 0, 0, 24'h7FFF00, 1, 2));
		add_item(FUNC_CHOOSE, 9, 6, 16'h1234, 1'b1, status(0, 1, 0, 24'h7FFF00, 1, 2));
		add_cfg(CFG_GAIN, 16'hFFFF);
		add_cfg(CFG_MAX_STEPS, 16'd0);
		add_cfg(CFG_ROWS, 16'd0);
		add_cfg(CFG_COLS, 16'd31);
		// one row of sixteen columns, zero step limit means always done
		add_item(FUNC_CHOOSE, 0, 0, 16'h0000, 1'b1, status(0, 1, 1, 24'h7FFF00, 1, 2));
		// report below the grid in use is ignored
		add_item(FUNC_REPORT, 1, 0, 16'h0100, 1'b1, status(0, 0, 1, 24'h7FFF00, 1, 2));
		add_cfg(CFG_COLS, 16'd2);
		add_item(FUNC_REPORT, 0, 1, 16'h0155, 1'b0, '0);
		add_item(FUNC_REPORT, 0, 2, 16'h0155, 1'b0, '0);
		add_item(FUNC_CHOOSE, 0, 0, 16'h0000, 1'b0, '0);
		add_cfg(CFG_GAIN, 16'h0000);
		add_item(FUNC_CHOOSE, 0, 0, 16'h0000, 1'b0, '0);
		add_cfg(CFG_MAX_STEPS, 16'd5);
		add_item(FUNC_REPORT, 0, 0, 16'hFFFB, 1'b0, '0);
		add_item(FUNC_REPORT, 0, 1, 16'h8000, 1'b0, '0);
		add_item(FUNC_REPORT, 0, 1, 16'h7FFF, 1'b0, '0);
		add_cfg(CFG_MAX_STEPS, 16'hFFFF);
		add_cfg(CFG_ROWS, 16'd17);
		add_cfg(CFG_COLS, 16'd16);
		add_item(FUNC_CHOOSE, 0, 0, 16'h0000, 1'b0, '0);
		add_item(FUNC_REPORT, 8, 8, 16'h0001, 1'b0, '0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (steps[i]) begin
			if (steps[i].is_cfg)
				write_reg(steps[i].idx, steps[i].val);
			else
				send_item(steps[i].item, steps[i].typed, steps[i].res);
		end

		// random phases: fresh registers each time, mostly small grids
		for (int p = 0; p < 8; p++) begin
			pick = $urandom_range(0, 3);
			v = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
			write_reg(CFG_GAIN, v);
			pick = $urandom_range(0, 4);
			v = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 : (pick == 2) ? 16'hFFFF
				: 16'($urandom_range(2, 40));
			write_reg(CFG_MAX_STEPS, v);
			pick = $urandom_range(0, 5);
			v = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(17, 31))
				: 16'($urandom_range(1, 4));
			write_reg(CFG_ROWS, (p == 5) ? 16'd4 : v);
			pick = $urandom_range(0, 5);
			v = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(17, 31))
				: 16'($urandom_range(1, 4));
			write_reg(CFG_COLS, (p == 5) ? 16'd16 : v);
			nr = dim(rows_q, MAX_ROWS);
			nc = dim(cols_q, MAX_COLS);
			quiet = (p % 3 == 1);
			// long receiver hold while items keep coming, so the input backs up
			if (p == 2) begin
				quiet = 1'b1;
				hold_req = 1'b1;
			end
			for (int n = 0; n < 15; n++) begin
				pick = $urandom_range(0, 9);
				x.func = (pick < 3) ? FUNC_CHOOSE : FUNC_REPORT;
				if (pick == 9) begin
					// stray report anywhere, may fall outside the grid
					x.row = 4'($urandom);
					x.col = 4'($urandom);
				end else begin
					x.row = 4'($urandom_range(0, nr - 1));
					x.col = 4'($urandom_range(0, nc - 1));
				end
				pick = $urandom_range(0, 9);
				x.signal = (pick == 0) ? 16'sh7FFF : (pick == 1) ? 16'sh8000
					: (pick < 5) ? 16'($urandom_range(0, 2047)) - 16'sd1024 : 16'($urandom);
				send_item(x, 1'b0, '0);
			end
		end

		drain();
		repeat (500) @(posedge clk);
		$display("covered %0d items (%0d choose), %0d results checked", items_sent,
			chooses_sent, results_seen);
		$display("grid settings from 1x1 to full, gain and step limits at both extremes");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d errors, %0d results outstanding", errors, pending_results.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
